[rtl/rsap_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsap_pkg
// Shared types, codes and constants of the raid5 stripe access planner.
// ----------------------------------------------------------------------------
package rsap_pkg;

  localparam int RSAP_MAX_DISKS        = 16;
  localparam int RSAP_BLOCK_INDEX_BITS = 48;

  localparam int IDX_W    = 48;
  localparam int REM_W    = 32;
  localparam int OFF_W    = 63;
  localparam int MASK_W   = 16;
  localparam int DISK_W   = 4;
  localparam int CNT_W    = 5;
  localparam int MOD_W    = 8;
  localparam int BB_W     = 21;
  localparam int DIV_STEP = 8;

  localparam logic [1:0] MODE_READ    = 2'd0;
  localparam logic [1:0] MODE_WRITE   = 2'd1;
  localparam logic [1:0] MODE_REBUILD = 2'd2;

  localparam logic [1:0] ST_OK             = 2'd0;
  localparam logic [1:0] ST_DATA_PARITY    = 2'd1;
  localparam logic [1:0] ST_OTHER_MISSING  = 2'd2;
  localparam logic [1:0] ST_PARITY_WRITE   = 2'd3;

  localparam logic [1:0] REG_DISK_COUNT   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BYTES  = 2'd1;
  localparam logic [1:0] REG_MISSING_MASK = 2'd2;
  localparam logic [1:0] REG_REBUILD_DISK = 2'd3;

  localparam logic [CNT_W-1:0]  RST_DISK_COUNT   = 5'd3;
  localparam logic [BB_W-1:0]   RST_BLOCK_BYTES  = 21'd4096;
  localparam logic [MASK_W-1:0] RST_MISSING_MASK = 16'd0;
  localparam logic [DISK_W-1:0] RST_REBUILD_DISK = 4'd0;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] block_index;
    logic [REM_W-1:0] blocks_remaining;
  } rsap_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              full_stripe;
    logic [IDX_W-1:0]  stripe_number;
    logic [DISK_W-1:0] target_disk;
    logic [DISK_W-1:0] parity_idx;
    logic [OFF_W-1:0]  disk_byte_offset;
    logic [MASK_W-1:0] read_mask;
    logic [MASK_W-1:0] write_mask;
    logic [DISK_W-1:0] blocks_consumed;
  } rsap_out_t;

  // divisors of the current array geometry
  typedef struct packed {
    logic [CNT_W-1:0]  n;
    logic [DISK_W-1:0] d;
    logic [MOD_W-1:0]  m;
  } rsap_divs_t;

  // one item inside the divider pipeline
  typedef struct packed {
    logic [1:0]        mode;
    logic [IDX_W-1:0]  idx;
    logic [REM_W-1:0]  remaining;
    logic [IDX_W-1:0]  sh;
    logic [IDX_W-1:0]  quo;
    logic [DISK_W-1:0] rem;
    logic [MOD_W-1:0]  mrem;
  } rsap_div_t;

endpackage

[rtl/rsap_div_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsap_div_stage
// One registered divider stage: eight dividend bits per stage, giving block
// index over n-1 and the parallel residue used for the parity rotation.
// ----------------------------------------------------------------------------
module rsap_div_stage import rsap_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  logic       valid_i,
  input  rsap_div_t  data_i,
  input  rsap_divs_t divs_i,
  output logic       valid_o,
  output rsap_div_t  data_o
);

  logic      valid_q;
  rsap_div_t data_q;
  rsap_div_t data_d;

  always_comb begin
    logic [CNT_W-1:0] r5;
    logic [MOD_W:0]   m9;
    logic [MOD_W-1:0] m;
    logic             qb;
    data_d = data_i;
    // rebuild takes the stripe mod n directly, others mod n*(n-1)
    m = (data_i.mode == MODE_REBUILD) ? MOD_W'(divs_i.n) : divs_i.m;
    for (int i = 0; i < DIV_STEP; i++) begin
      r5 = {data_d.rem, data_d.sh[IDX_W-1]};
      qb = 1'b0;
      if (r5 >= {1'b0, divs_i.d}) begin
        r5 = r5 - {1'b0, divs_i.d};
        qb = 1'b1;
      end
      data_d.rem = r5[DISK_W-1:0];
      data_d.quo = {data_d.quo[IDX_W-2:0], qb};
      m9 = {data_d.mrem, data_d.sh[IDX_W-1]};
      if (m9 >= {1'b0, m}) begin
        m9 = m9 - {1'b0, m};
      end
      data_d.mrem = m9[MOD_W-1:0];
      data_d.sh = {data_d.sh[IDX_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/raid5_stripe_access_planner_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raid5_stripe_access_planner_core
// Right-asymmetric raid5 request mapping: stripe, data and parity disks, byte
// offset, read and write disk masks, blocks consumed and status.
// ----------------------------------------------------------------------------
// One request is taken per cycle while the pipeline is not held full by an
// output stall. Each request gives one result after passing through an
// input register, the divider stages that retire eight quotient bits each,
// one stage for the parity disk and the offset partial products, and the
// output register. Bubbles collapse on stall, so requests keep entering
// while a result waits. The user writes the registers over the apb port
// only while no request is in flight; the block does not enforce this.
module raid5_stripe_access_planner_core import rsap_pkg::*; #(
  parameter int MAX_DISKS        = RSAP_MAX_DISKS,
  parameter int BLOCK_INDEX_BITS = RSAP_BLOCK_INDEX_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  rsap_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsap_out_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW     = (BLOCK_INDEX_BITS < IDX_W) ? BLOCK_INDEX_BITS : IDX_W;
  localparam int NSTG   = (IW + DIV_STEP - 1) / DIV_STEP;
  localparam int DW     = NSTG * DIV_STEP;
  localparam int SH_AMT = IDX_W - DW;
  localparam int S      = NSTG + 3;
  localparam int HALF   = IDX_W / 2;
  localparam int PP_W   = HALF + BB_W;
  localparam logic [IDX_W-1:0] IDX_MASK = {IDX_W{1'b1}} >> (IDX_W - IW);

  typedef struct packed {
    logic [1:0]        mode;
    logic [REM_W-1:0]  remaining;
    logic [IDX_W-1:0]  stripe;
    logic [DISK_W-1:0] target;
    logic [DISK_W-1:0] pdisk;
    logic [DISK_W-1:0] pos;
    logic [PP_W-1:0]   plo;
    logic [PP_W-1:0]   phi;
  } rsap_map_t;

  // configuration registers
  logic [CNT_W-1:0]  disk_count_q;
  logic [BB_W-1:0]   block_bytes_q;
  logic [MASK_W-1:0] missing_mask_q;
  logic [DISK_W-1:0] rebuild_disk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_count_q   <= RST_DISK_COUNT;
      block_bytes_q  <= RST_BLOCK_BYTES;
      missing_mask_q <= RST_MISSING_MASK;
      rebuild_disk_q <= RST_REBUILD_DISK;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_DISK_COUNT:   disk_count_q   <= pwdata[CNT_W-1:0];
        REG_BLOCK_BYTES:  block_bytes_q  <= pwdata[BB_W-1:0];
        REG_MISSING_MASK: missing_mask_q <= pwdata[MASK_W-1:0];
        REG_REBUILD_DISK: rebuild_disk_q <= pwdata[DISK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DISK_COUNT:   prdata = 32'(disk_count_q);
      REG_BLOCK_BYTES:  prdata = 32'(block_bytes_q);
      REG_MISSING_MASK: prdata = 32'(missing_mask_q);
      REG_REBUILD_DISK: prdata = 32'(rebuild_disk_q);
      default:          prdata = 32'd0;
    endcase
  end

  assign pready = 1'b1;

  // array geometry
  logic [CNT_W-1:0]  n_w;
  logic [DISK_W-1:0] d_w;
  logic [MASK_W-1:0] all_w;
  logic [MASK_W-1:0] miss_w;
  logic [MASK_W-1:0] present_w;
  rsap_divs_t        divs_w;

  always_comb begin
    if (disk_count_q < 5'd3) begin
      n_w = 5'd3;
    end else if (disk_count_q > CNT_W'(MAX_DISKS)) begin
      n_w = CNT_W'(MAX_DISKS);
    end else begin
      n_w = disk_count_q;
    end
  end

  assign d_w       = DISK_W'(n_w - 5'd1);
  assign all_w     = MASK_W'((17'd1 << n_w) - 17'd1);
  assign miss_w    = missing_mask_q & all_w;
  assign present_w = all_w & ~miss_w;
  assign divs_w.n  = n_w;
  assign divs_w.d  = d_w;
  assign divs_w.m  = MOD_W'(n_w) * MOD_W'(d_w);

  // pipeline flow control
  logic            v0_q;
  logic [NSTG:1]   dv;
  logic            map_v_q;
  logic            out_v_q;
  logic [S-1:0]    stg_v;
  logic [S:0]      load;

  assign stg_v   = {out_v_q, map_v_q, dv, v0_q};
  assign load[S] = !out_stall_i;

  for (genvar k = 0; k < S; k++) begin : g_load
    assign load[k] = !stg_v[k] || load[k+1];
  end

  assign in_stall_o = !load[0];

  // input register
  rsap_div_t d0_q;
  rsap_div_t dq [1:NSTG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (load[0]) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      d0_q.mode      <= in_data_i.mode;
      d0_q.idx       <= in_data_i.block_index & IDX_MASK;
      d0_q.remaining <= in_data_i.blocks_remaining;
      d0_q.sh        <= (in_data_i.block_index & IDX_MASK) << SH_AMT;
      d0_q.quo       <= '0;
      d0_q.rem       <= '0;
      d0_q.mrem      <= '0;
    end
  end

  // divider stages
  for (genvar k = 1; k <= NSTG; k++) begin : g_div
    logic      vin;
    rsap_div_t din;
    if (k == 1) begin : g_first
      assign vin = v0_q;
      assign din = d0_q;
    end else begin : g_rest
      assign vin = dv[k-1];
      assign din = dq[k-1];
    end
    rsap_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (load[k]),
      .valid_i (vin),
      .data_i  (din),
      .divs_i  (divs_w),
      .valid_o (dv[k]),
      .data_o  (dq[k])
    );
  end

  // parity disk, data disk and offset partial products
  rsap_map_t map_d;
  rsap_map_t map_q;

  always_comb begin
    logic [DISK_W-1:0] sr;
    logic [CNT_W-1:0]  r5;
    logic [DISK_W-1:0] pq;
    rsap_div_t         dd;
    dd = dq[NSTG];
    sr = dd.mrem[MOD_W-1:DISK_W];
    pq = '0;
    for (int i = DISK_W - 1; i >= 0; i--) begin
      r5 = {sr, dd.mrem[i]};
      if (r5 >= {1'b0, d_w}) begin
        r5    = r5 - {1'b0, d_w};
        pq[i] = 1'b1;
      end
      sr = r5[DISK_W-1:0];
    end
    map_d.mode      = dd.mode;
    map_d.remaining = dd.remaining;
    map_d.pos       = dd.rem;
    if (dd.mode == MODE_REBUILD) begin
      map_d.stripe = dd.idx;
      map_d.pdisk  = dd.mrem[DISK_W-1:0];
      map_d.target = rebuild_disk_q;
    end else begin
      map_d.stripe = dd.quo;
      map_d.pdisk  = pq;
      map_d.target = (dd.rem >= pq) ? dd.rem + 4'd1 : dd.rem;
    end
    map_d.plo = PP_W'(map_d.stripe[HALF-1:0]) * PP_W'(block_bytes_q);
    map_d.phi = PP_W'(map_d.stripe[IDX_W-1:HALF]) * PP_W'(block_bytes_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_v_q <= 1'b0;
    end else if (load[NSTG+1]) begin
      map_v_q <= dv[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[NSTG+1]) begin
      map_q <= map_d;
    end
  end

  // access plan and output register
  rsap_out_t out_d;
  rsap_out_t out_q;

  always_comb begin
    logic [MASK_W-1:0] pbit;
    logic [MASK_W-1:0] dbit;
    logic [MASK_W-1:0] need;
    logic              p_ok;
    logic              d_ok;
    pbit = MASK_W'(1) << map_q.pdisk;
    dbit = MASK_W'(1) << map_q.target;
    p_ok = |(present_w & pbit);
    d_ok = |(present_w & dbit);
    need = '0;
    out_d.status           = ST_OK;
    out_d.full_stripe      = 1'b0;
    out_d.stripe_number    = map_q.stripe;
    out_d.target_disk      = map_q.target;
    out_d.parity_idx       = map_q.pdisk;
    out_d.disk_byte_offset = OFF_W'({map_q.phi, {HALF{1'b0}}}) + OFF_W'(map_q.plo);
    out_d.read_mask        = '0;
    out_d.write_mask       = '0;
    out_d.blocks_consumed  = 4'd1;
    case (map_q.mode)
      MODE_REBUILD: begin
        if (({1'b0, map_q.target} >= n_w) || miss_w[map_q.target]) begin
          out_d.status = ST_OTHER_MISSING;
        end else if (map_q.target == map_q.pdisk) begin
          need = all_w & ~pbit;
          if (|(miss_w & need)) begin
            out_d.status = ST_OTHER_MISSING;
          end else begin
            out_d.read_mask  = need;
            out_d.write_mask = pbit;
          end
        end else begin
          need = all_w & ~pbit & ~dbit;
          if (|(miss_w & need)) begin
            out_d.status = ST_OTHER_MISSING;
          end else begin
            out_d.read_mask  = need | (pbit & present_w);
            out_d.write_mask = dbit;
          end
        end
      end
      MODE_WRITE: begin
        if ((map_q.pos == '0) && (map_q.remaining >= REM_W'(d_w))) begin
          out_d.full_stripe     = 1'b1;
          out_d.blocks_consumed = d_w;
          if (p_ok) begin
            out_d.write_mask = present_w;
          end else begin
            out_d.write_mask = present_w & ~pbit;
            out_d.status     = ST_PARITY_WRITE;
          end
        end else if (p_ok) begin
          out_d.read_mask  = (d_ok ? dbit : '0) | pbit;
          out_d.write_mask = (d_ok ? dbit : '0) | pbit;
        end else begin
          out_d.status     = ST_PARITY_WRITE;
          out_d.write_mask = d_ok ? dbit : '0;
        end
      end
      default: begin
        if (d_ok) begin
          out_d.read_mask = dbit;
        end else if (!p_ok) begin
          out_d.status = ST_DATA_PARITY;
        end else if (|(miss_w & ~dbit & ~pbit)) begin
          out_d.status = ST_OTHER_MISSING;
        end else begin
          out_d.read_mask = all_w & ~dbit;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load[NSTG+2]) begin
      out_v_q <= map_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[NSTG+2]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the raid5 stripe access planner core. Requests are
// fed through a bursty driver, results are taken under a changing stall
// pattern and checked field by field against a local right-asymmetric
// mapping model. The array geometry is reprogrammed over apb between phases.
// ----------------------------------------------------------------------------
module tb import rsap_pkg::*;;

  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int DRAIN_CYCLES    = 16;
  localparam int WATCHDOG_LIMIT  = 2000;

  localparam logic [IDX_W-1:0] MAX_IDX = {IDX_W{1'b1}};
  localparam logic [REM_W-1:0] MAX_REM = {REM_W{1'b1}};

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  rsap_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rsap_out_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [CNT_W-1:0]  cfg_disks   = RST_DISK_COUNT;
  logic [BB_W-1:0]   cfg_bytes   = RST_BLOCK_BYTES;
  logic [MASK_W-1:0] cfg_missing = RST_MISSING_MASK;
  logic [DISK_W-1:0] cfg_rebuild = RST_REBUILD_DISK;

  rsap_in_t  req_queue[$];
  rsap_out_t plan_queue[$];
  rsap_out_t want_plan;

  int errors       = 0;
  int idle_cycles  = 0;
  int burst_left   = 0;
  int gap_left     = 0;
  int stall_kind   = 0;
  int stall_run    = 0;
  int stall_period = 2;
  int stall_tick   = 0;
  bit in_took      = 1'b0;

  raid5_stripe_access_planner_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic rsap_out_t plan_access(input rsap_in_t req);
    rsap_out_t         plan;
    int unsigned       n;
    logic [63:0]       idx, stripe, pos, pdisk, tdisk;
    logic [REM_W-1:0]  remaining;
    logic [MASK_W-1:0] all_disks, miss, present, pbit, dbit, rbit, need;
    logic              p_ok, d_ok;
    n = cfg_disks;
    if (n < 3) n = 3;
    if (n > RSAP_MAX_DISKS) n = RSAP_MAX_DISKS;
    all_disks = 16'((32'd1 << n) - 32'd1);
    miss      = cfg_missing & all_disks;
    present   = all_disks & ~miss;
    idx       = 64'(req.block_index);
    remaining = req.blocks_remaining;
    plan      = '0;
    plan.blocks_consumed = 4'd1;
    if (req.mode == MODE_REBUILD) begin
      stripe = idx;
      pdisk  = stripe % n;
      tdisk  = 64'(cfg_rebuild);
      pbit   = 16'd1 << pdisk[3:0];
      if (tdisk >= n || miss[tdisk[3:0]]) begin
        plan.status = ST_OTHER_MISSING;
      end else begin
        rbit = 16'd1 << tdisk[3:0];
        if (tdisk == pdisk) begin
          need = all_disks & ~pbit;
          if ((miss & need) != 0) begin
            plan.status = ST_OTHER_MISSING;
          end else begin
            plan.read_mask  = need;
            plan.write_mask = pbit;
          end
        end else begin
          need = all_disks & ~pbit & ~rbit;
          if ((miss & need) != 0) begin
            plan.status = ST_OTHER_MISSING;
          end else begin
            // absent parity disk contributes zeros
            plan.read_mask  = need | (pbit & present);
            plan.write_mask = rbit;
          end
        end
      end
    end else begin
      stripe = idx / (n - 1);
      pos    = idx % (n - 1);
      pdisk  = stripe % n;
      tdisk  = (pos >= pdisk) ? pos + 1 : pos;
      pbit   = 16'd1 << pdisk[3:0];
      dbit   = 16'd1 << tdisk[3:0];
      p_ok   = (present & pbit) != 0;
      d_ok   = (present & dbit) != 0;
      if (req.mode == MODE_WRITE) begin
        if (pos == 0 && remaining >= n - 1) begin
          plan.full_stripe     = 1'b1;
          plan.blocks_consumed = 4'(n - 1);
          plan.write_mask      = present & ~pbit;
          if (p_ok) plan.write_mask = plan.write_mask | pbit;
          else plan.status = ST_PARITY_WRITE;
        end else if (p_ok) begin
          plan.read_mask  = (d_ok ? dbit : 16'd0) | pbit;
          plan.write_mask = (d_ok ? dbit : 16'd0) | pbit;
        end else begin
          plan.status     = ST_PARITY_WRITE;
          plan.write_mask = d_ok ? dbit : 16'd0;
        end
      end else begin
        if (d_ok) begin
          plan.read_mask = dbit;
        end else if (!p_ok) begin
          plan.status = ST_DATA_PARITY;
        end else if ((miss & ~dbit & ~pbit) != 0) begin
          plan.status = ST_OTHER_MISSING;
        end else begin
          plan.read_mask = all_disks & ~dbit;
        end
      end
    end
    plan.stripe_number    = stripe[IDX_W-1:0];
    plan.target_disk      = tdisk[DISK_W-1:0];
    plan.parity_idx       = pdisk[DISK_W-1:0];
    plan.disk_byte_offset = 63'(stripe * 64'(cfg_bytes));
    return plan;
  endfunction

  function automatic rsap_in_t make_req(input logic [1:0] mode, input logic [IDX_W-1:0] idx,
                                        input logic [REM_W-1:0] remaining);
    rsap_in_t req;
    req.mode             = mode;
    req.block_index      = idx;
    req.blocks_remaining = remaining;
    return req;
  endfunction

  function automatic rsap_in_t random_req(input int unsigned n);
    logic [1:0]       mode;
    logic [IDX_W-1:0] idx;
    logic [REM_W-1:0] remaining;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: mode = MODE_READ;
      4, 5, 6:    mode = MODE_WRITE;
      7, 8:       mode = MODE_REBUILD;
      default:    mode = 2'd3;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: idx = IDX_W'($urandom_range(0, 300));
      4, 5:       idx = IDX_W'((n - 1) * $urandom_range(0, 5000));
      6, 7:       idx = IDX_W'({$urandom, $urandom});
      8:          idx = MAX_IDX - IDX_W'($urandom_range(0, 50));
      default:    idx = IDX_W'(64'(n - 1) * 64'($urandom));
    endcase
    case ($urandom_range(0, 9))
      0:       remaining = '0;
      1, 2, 3: remaining = REM_W'($urandom_range(0, 2 * n));
      4:       remaining = REM_W'(n - 1);
      5:       remaining = REM_W'(n - 2);
      6, 7:    remaining = $urandom;
      8:       remaining = MAX_REM;
      default: remaining = REM_W'($urandom_range(0, 20));
    endcase
    return make_req(mode, idx, remaining);
  endfunction

  task automatic add_directed(input int unsigned n, input int unsigned rebuild);
    for (int m = 0; m < 4; m++) begin
      req_queue.push_back(make_req(2'(m), '0, '0));
      req_queue.push_back(make_req(2'(m), MAX_IDX, MAX_REM));
    end
    req_queue.push_back(make_req(MODE_WRITE, IDX_W'(n - 1), REM_W'(n - 1)));
    req_queue.push_back(make_req(MODE_WRITE, IDX_W'(2 * (n - 1) + 1), REM_W'(1)));
    req_queue.push_back(make_req(MODE_REBUILD, IDX_W'(rebuild), '0));
    req_queue.push_back(make_req(MODE_REBUILD, IDX_W'(rebuild + 1), '0));
  endtask

  task automatic write_reg(input logic [1:0] reg_idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (reg_idx)
      REG_DISK_COUNT:   cfg_disks   = value[CNT_W-1:0];
      REG_BLOCK_BYTES:  cfg_bytes   = value[BB_W-1:0];
      REG_MISSING_MASK: cfg_missing = value[MASK_W-1:0];
      default:          cfg_rebuild = value[DISK_W-1:0];
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    #1;
    while (!(req_queue.size() == 0 && !in_valid && plan_queue.size() == 0)) begin
      @(posedge clk_i);
      #1;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (req_queue.size() != 0) begin
        in_data  <= req_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else if ($urandom_range(0, 4) == 0) begin
          burst_left = $urandom_range(40, 200);
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(0, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall pattern
  always @(negedge clk_i) begin
    if (stall_run == 0) begin
      stall_kind   = $urandom_range(0, 3);
      stall_run    = $urandom_range(16, 200);
      stall_period = $urandom_range(2, 9);
    end
    stall_run--;
    stall_tick++;
    case (stall_kind)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 99) < 35);
      2:       out_stall <= (stall_tick % stall_period) < (stall_period / 2);
      default: out_stall <= ($urandom_range(0, 99) < 85);
    endcase
  end

  // request transfer: predict the plan
  always @(posedge clk_i) begin
    in_took = rst_ni && in_valid && !in_stall;
    if (in_took) plan_queue.push_back(plan_access(in_data));
  end

  // result transfer: compare with the oldest plan
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (plan_queue.size() == 0) begin
        $display("%0t ns: result with no request pending, expected none, actual %h",
                 $time, out_data);
        errors++;
      end else begin
        want_plan = plan_queue.pop_front();
        check_field("status", 64'(want_plan.status), 64'(out_data.status));
        check_field("full_stripe", 64'(want_plan.full_stripe), 64'(out_data.full_stripe));
        check_field("stripe_number", 64'(want_plan.stripe_number),
                    64'(out_data.stripe_number));
        check_field("target_disk", 64'(want_plan.target_disk), 64'(out_data.target_disk));
        check_field("parity_idx", 64'(want_plan.parity_idx), 64'(out_data.parity_idx));
        check_field("disk_byte_offset", 64'(want_plan.disk_byte_offset),
                    64'(out_data.disk_byte_offset));
        check_field("read_mask", 64'(want_plan.read_mask), 64'(out_data.read_mask));
        check_field("write_mask", 64'(want_plan.write_mask), 64'(out_data.write_mask));
        check_field("blocks_consumed", 64'(want_plan.blocks_consumed),
                    64'(out_data.blocks_consumed));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [CNT_W-1:0]  dc;
    logic [BB_W-1:0]   bb;
    logic [MASK_W-1:0] mm;
    logic [DISK_W-1:0] rb;
    int unsigned       n;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin dc = 5'd5;  bb = 21'd1048576; mm = 16'h0000; rb = 4'd4;  end
        1: begin dc = 5'd5;  bb = 21'd1;       mm = 16'h8011; rb = 4'd0;  end
        2: begin dc = 5'd0;  bb = 21'h1FFFFF;  mm = 16'hFFFF; rb = 4'd15; end
        3: begin dc = 5'd16; bb = 21'd4096;    mm = 16'h0000; rb = 4'd15; end
        4: begin
          dc = 5'd31;
          bb = 21'd0;
          mm = 16'd1 << $urandom_range(0, 15);
          rb = 4'($urandom_range(0, 15));
        end
        5: begin dc = 5'd2;  bb = 21'd512;     mm = 16'h0000; rb = 4'd0;  end
        6: begin dc = 5'd3;  bb = 21'd1;       mm = 16'h0002; rb = 4'd1;  end
        default: begin
          dc = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(3, 16));
          case ($urandom_range(0, 5))
            0:       bb = 21'd1;
            1:       bb = 21'd512;
            2:       bb = 21'd4096;
            3:       bb = 21'($urandom_range(1, 1048576));
            4:       bb = 21'd1048576;
            default: bb = 21'($urandom);
          endcase
          case ($urandom_range(0, 4))
            0, 1:    mm = 16'h0000;
            2:       mm = 16'd1 << $urandom_range(0, 15);
            3:       mm = (16'd1 << $urandom_range(0, 15)) | (16'd1 << $urandom_range(0, 15));
            default: mm = 16'($urandom);
          endcase
          rb = 4'($urandom_range(0, 15));
        end
      endcase
      n = dc;
      if (n < 3) n = 3;
      if (n > RSAP_MAX_DISKS) n = RSAP_MAX_DISKS;
      if (p > 6 && $urandom_range(0, 3) != 0) rb = 4'($urandom_range(0, n - 1));
      write_reg(REG_DISK_COUNT, 32'(dc));
      write_reg(REG_BLOCK_BYTES, 32'(bb));
      write_reg(REG_MISSING_MASK, 32'(mm));
      write_reg(REG_REBUILD_DISK, 32'(rb));
      if (p < 2) add_directed(n, rb);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // in phase 3 the sender holds off mid-phase until the pipeline has drained
        if (p == 3 && i == ITEMS_PER_PHASE / 2) wait_idle();
        req_queue.push_back(random_req(n));
      end
      wait_idle();
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
